>>> rtl/core/audio_block_level_meter_defines.svh
// Assertion macros for the level meter checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef AUDIO_BLOCK_LEVEL_METER_DEFINES_SVH
`define AUDIO_BLOCK_LEVEL_METER_DEFINES_SVH

// Same-cycle implication, off while reset is asserted
`define ABLM_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted
`define ABLM_ASSERT_NXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

// Next-cycle implication that also runs through reset
`define ABLM_ASSERT_RST(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> rtl/core/ablm_pkg.sv
`default_nettype none
package ablm_pkg;

  // Fixed field widths
  localparam int CH_W      = 3;
  localparam int SMP_W     = 24;
  localparam int CFG_W     = 13;
  localparam logic [CFG_W-1:0] CFG_RESET = 13'd1024;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic square;
    logic accum;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic chan_ok;
    logic blk_done;
  } dp_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/ablm_ctrl.sv
`default_nettype none
module ablm_ctrl #(
  parameter int MAX_BLOCK = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output ablm_pkg::dp_cmd_t cmd,
  input  ablm_pkg::dp_sts_t sts
);
  import ablm_pkg::*;

  localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W  = 2 * (SMP_W - 1) + CNT_W;
  localparam int SQ_W   = SUM_W + (SUM_W % 2);
  localparam int RT_W   = SQ_W / 2;
  localparam int STEP_W = $clog2(SUM_W);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_SQI  = 3'd4;
  localparam logic [2:0] ST_SQRT = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              in_take;

  assign in_stall  = !rst_n || (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // Sequence one word through square, accumulate, divide and root
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        cmd.capture = in_take;
        if (in_take && sts.chan_ok) begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.square = 1'b1;
        state_nxt  = ST_ACC;
      end
      ST_ACC: begin
        cmd.accum = 1'b1;
        if (sts.blk_done) begin
          state_nxt = ST_DIV;
          step_nxt  = STEP_W'(SUM_W - 1);
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_SQI;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      ST_SQI: begin
        cmd.sqrt_init = 1'b1;
        step_nxt      = STEP_W'(RT_W - 1);
        state_nxt     = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      ST_OUT: begin
        // Hold until the output register is free or being drained
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/ablm_dp.sv
`default_nettype none
module ablm_dp #(
  parameter int CHANNELS  = 8,
  parameter int MAX_BLOCK = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic        [ablm_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic        [ablm_pkg::CH_W-1:0]    in_channel,
  input  logic signed [ablm_pkg::SMP_W-1:0]   in_sample,
  output logic        [ablm_pkg::CH_W-1:0]    out_channel,
  output logic        [ablm_pkg::SMP_W-1:0]   out_rms_level,
  output logic        [ablm_pkg::SMP_W-1:0]   out_peak_level,
  input  ablm_pkg::dp_cmd_t                   cmd,
  output ablm_pkg::dp_sts_t                   sts
);
  import ablm_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int SQR_W = 2 * SMP_W - 1;
  localparam int SUM_W = 2 * (SMP_W - 1) + CNT_W;
  localparam int SQ_W  = SUM_W + (SUM_W % 2);
  localparam int RT_W  = SQ_W / 2;
  localparam int SR_W  = RT_W + 1;
  localparam int ENT_W = SUM_W + SMP_W + CNT_W;

  // Block length register
  logic [CFG_W-1:0] cfg_r;
  logic [31:0]      len_ext;
  logic [CNT_W-1:0] len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  // Clamp the length to 1..MAX_BLOCK
  always_comb begin
    len_ext = 32'(cfg_r);
    if (len_ext == 32'd0) begin
      len_ext = 32'd1;
    end else if (len_ext > 32'(MAX_BLOCK)) begin
      len_ext = 32'(MAX_BLOCK);
    end
    len = len_ext[CNT_W-1:0];
  end

  // Input decode: channel index and sample magnitude
  logic [IDX_W+CH_W-1:0] chan_ext;
  logic [IDX_W-1:0]      in_idx;
  logic                  chan_ok;
  logic [SMP_W-1:0]      smp_u;
  logic [SMP_W-1:0]      mag;

  assign chan_ext = (IDX_W + CH_W)'(in_channel);
  assign in_idx   = chan_ext[IDX_W-1:0];
  assign chan_ok  = (32'(in_channel) < 32'(CHANNELS));
  assign smp_u    = in_sample;
  assign mag      = smp_u[SMP_W-1] ? (~smp_u + 1'b1) : smp_u;

  logic [CH_W-1:0]  ch_r;
  logic [IDX_W-1:0] idx_r;
  logic [SMP_W-1:0] mag_r;
  logic [SQR_W-1:0] sq_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch_r  <= in_channel;
      idx_r <= in_idx;
      mag_r <= mag;
    end
    if (cmd.square) begin
      sq_r <= SQR_W'(mag_r * mag_r);
    end
  end

  // Channel store: {sum, peak, count} per channel, valid bits clear at reset
  logic [ENT_W-1:0]    mem [CHANNELS];
  logic [CHANNELS-1:0] vld_r;
  logic [ENT_W-1:0]    rd_ent_r;
  logic                rd_vld_r;
  logic [ENT_W-1:0]    wr_ent;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_ent_r <= mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accum) begin
      mem[idx_r] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        rd_vld_r <= vld_r[in_idx];
      end
      if (cmd.accum) begin
        vld_r[idx_r] <= 1'b1;
      end
    end
  end

  // Accumulate the new sample into the channel entry
  logic [SUM_W-1:0] cur_sum, new_sum;
  logic [SMP_W-1:0] cur_peak, new_peak;
  logic [CNT_W-1:0] cur_cnt, new_cnt;
  logic             done;

  always_comb begin
    cur_sum  = rd_vld_r ? rd_ent_r[ENT_W-1 -: SUM_W] : '0;
    cur_peak = rd_vld_r ? rd_ent_r[CNT_W +: SMP_W] : '0;
    cur_cnt  = rd_vld_r ? rd_ent_r[CNT_W-1:0] : '0;
    new_sum  = cur_sum + SUM_W'(sq_r);
    new_peak = (mag_r > cur_peak) ? mag_r : cur_peak;
    new_cnt  = cur_cnt + 1'b1;
    done     = (new_cnt >= len);
    wr_ent   = done ? '0 : {new_sum, new_peak, new_cnt};
  end

  assign sts = '{chan_ok: chan_ok, blk_done: done};

  // Restoring divider: one quotient bit per cycle, quotient shifts into num_r
  logic [SUM_W-1:0] num_r;
  logic [CNT_W-1:0] den_r;
  logic [CNT_W-1:0] rem_r;
  logic [SMP_W-1:0] peak_r;
  logic [CNT_W:0]   rem_sh;
  logic             rem_ge;

  assign rem_sh = {rem_r, num_r[SUM_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (cmd.accum) begin
      num_r  <= new_sum;
      den_r  <= new_cnt;
      rem_r  <= '0;
      peak_r <= new_peak;
    end else if (cmd.div_step) begin
      num_r <= {num_r[SUM_W-2:0], rem_ge};
      rem_r <= rem_ge ? CNT_W'(rem_sh - {1'b0, den_r}) : rem_sh[CNT_W-1:0];
    end
  end

  // Digit-by-digit square root: one root bit per cycle
  logic [SQ_W-1:0]   rad_r;
  logic [RT_W-1:0]   root_r;
  logic [SR_W-1:0]   srem_r;
  logic [SR_W+1:0]   srem_sh;
  logic [SR_W+1:0]   trial;
  logic              root_ge;

  assign srem_sh = {srem_r, rad_r[SQ_W-1 -: 2]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign root_ge = (srem_sh >= trial);

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      rad_r  <= SQ_W'(num_r);
      root_r <= '0;
      srem_r <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r  <= {rad_r[SQ_W-3:0], 2'b00};
      root_r <= {root_r[RT_W-2:0], root_ge};
      srem_r <= root_ge ? SR_W'(srem_sh - trial) : srem_sh[SR_W-1:0];
    end
  end

  // Output register
  logic [CH_W-1:0]  out_ch_r;
  logic [SMP_W-1:0] out_rms_r;
  logic [SMP_W-1:0] out_peak_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch_r   <= ch_r;
      out_rms_r  <= root_r[SMP_W-1:0];
      out_peak_r <= peak_r;
    end
  end

  assign out_channel    = out_ch_r;
  assign out_rms_level  = out_rms_r;
  assign out_peak_level = out_peak_r;

endmodule
`default_nettype wire

>>> rtl/core/audio_block_level_meter.sv
// Block RMS and peak level meter. Each input word carries a channel number and a
// signed Q1.23 sample; per channel the block keeps an exact sum of squares, the peak
// magnitude and a sample count. When a channel has collected block_length samples
// (cfg_wr_data, 0 acts as 1, values above MAX_BLOCK saturate) one result word gives
// that channel, floor(sqrt(sum / count)) and the peak, and the channel store clears.
// Samples for channels at or above CHANNELS are dropped. One word is handled at a
// time: each sample is captured, squared and accumulated, and a sample that finishes
// a block then also goes through the restoring divider and the square-root unit,
// which each resolve one bit per cycle (SUM_W = 46 + clog2(MAX_BLOCK + 1),
// RT_W = ceil(SUM_W/2)), and then waits while an earlier result still sits stalled
// in the output register.
// The output register lets the next sample be accepted while a result waits.
// Write block_length only while the block is idle.
`default_nettype none
module audio_block_level_meter #(
  parameter int CHANNELS  = 8,
  parameter int MAX_BLOCK = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic        [ablm_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic        [ablm_pkg::CH_W-1:0]    in_channel,
  input  logic signed [ablm_pkg::SMP_W-1:0]   in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [ablm_pkg::CH_W-1:0]    out_channel,
  output logic        [ablm_pkg::SMP_W-1:0]   out_rms_level,
  output logic        [ablm_pkg::SMP_W-1:0]   out_peak_level
);
  import ablm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ablm_ctrl #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  ablm_dp #(
    .CHANNELS  (CHANNELS),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_channel     (in_channel),
    .in_sample      (in_sample),
    .out_channel    (out_channel),
    .out_rms_level  (out_rms_level),
    .out_peak_level (out_peak_level),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule
`default_nettype wire

>>> rtl/core/ablm_checker.sv
`default_nettype none
`include "audio_block_level_meter_defines.svh"
module ablm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_channel,
  input wire logic [23:0] out_rms_level,
  input wire logic [23:0] out_peak_level
);

  // A stalled result word stays put
  `ABLM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_channel) && $stable(out_rms_level) && $stable(out_peak_level), "result word changed while stalled")

  // RMS over a block never exceeds its peak
  `ABLM_ASSERT_IMP(a_rms_le_peak, out_valid, out_rms_level <= out_peak_level, "rms level above peak level")

  // Peak magnitude is at most full scale
  `ABLM_ASSERT_IMP(a_peak_range, out_valid, out_peak_level <= 24'd8388608, "peak level above full scale")

  // Reset drops any pending result
  `ABLM_ASSERT_RST(a_rst_empty, !rst_n, !out_valid, "result valid right after reset")

endmodule

bind audio_block_level_meter ablm_checker u_ablm_checker (.*);
`default_nettype wire

>>> dv/level_meter_sb_pkg.sv
`timescale 1ns / 100ps
package level_meter_sb_pkg;

  localparam int NUM_CH    = 8;
  localparam int MAX_BLOCK = 4096;

  typedef struct {
    bit [ablm_pkg::CH_W-1:0]  chan;
    bit [ablm_pkg::SMP_W-1:0] rms;
    bit [ablm_pkg::SMP_W-1:0] peak;
  } level_word_t;

  class level_scoreboard;
    bit [58:0]                 square_sum [NUM_CH];
    bit [ablm_pkg::SMP_W-1:0]  peak_mag   [NUM_CH];
    bit [ablm_pkg::CFG_W-1:0]  sample_cnt [NUM_CH];
    bit [ablm_pkg::CFG_W-1:0]  block_len;
    level_word_t               expected_levels[$];
    int                        mismatches;
    int                        levels_checked;

    function new();
      for (int c = 0; c < NUM_CH; c++) begin
        square_sum[c] = '0;
        peak_mag[c]   = '0;
        sample_cnt[c] = '0;
      end
      block_len      = ablm_pkg::CFG_RESET;
      mismatches     = 0;
      levels_checked = 0;
    endfunction

    function void set_block_length(bit [ablm_pkg::CFG_W-1:0] len);
      block_len = len;
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction

    // Print one line per mismatch and count it
    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
    endtask

    // Bitwise integer square root, floor
    static function bit [63:0] floor_sqrt(bit [63:0] value);
      bit [63:0] rem;
      bit [63:0] root;
      bit [63:0] probe;
      rem   = value;
      root  = '0;
      probe = 64'h1 << 62;
      while (probe > rem)
        probe >>= 2;
      while (probe != 0) begin
        if (rem >= root + probe) begin
          rem  = rem - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root >>= 1;
        end
        probe >>= 2;
      end
      return root;
    endfunction

    // Accumulate one accepted sample; queue a level word when the block closes
    function void note_sample(bit [ablm_pkg::CH_W-1:0] ch, bit [ablm_pkg::SMP_W-1:0] raw);
      bit [ablm_pkg::SMP_W-1:0] mag;
      bit [58:0]                mag_w;
      bit [ablm_pkg::CFG_W-1:0] limit;
      bit [63:0]                mean;
      level_word_t              lvl;
      mag   = raw[ablm_pkg::SMP_W-1] ? (~raw + 1'b1) : raw;
      mag_w = mag;
      if (block_len == 0)
        limit = 1;
      else if (block_len > MAX_BLOCK)
        limit = MAX_BLOCK;
      else
        limit = block_len;
      square_sum[ch] = square_sum[ch] + mag_w * mag_w;
      if (mag > peak_mag[ch])
        peak_mag[ch] = mag;
      sample_cnt[ch] = sample_cnt[ch] + 1'b1;
      if (sample_cnt[ch] >= limit) begin
        mean     = 64'(square_sum[ch]) / 64'(sample_cnt[ch]);
        lvl.chan = ch;
        lvl.rms  = ablm_pkg::SMP_W'(floor_sqrt(mean));
        lvl.peak = peak_mag[ch];
        expected_levels.push_back(lvl);
        square_sum[ch] = '0;
        peak_mag[ch]   = '0;
        sample_cnt[ch] = '0;
      end
    endfunction

    // Compare one delivered level word with the oldest expectation
    task check_level(bit [ablm_pkg::CH_W-1:0] ch, bit [ablm_pkg::SMP_W-1:0] rms,
                     bit [ablm_pkg::SMP_W-1:0] peak);
      level_word_t lvl;
      levels_checked++;
      if (expected_levels.size() == 0) begin
        report_mismatch($sformatf("unexpected level word ch %0d rms %0d peak %0d",
                                  ch, rms, peak));
        return;
      end
      lvl = expected_levels.pop_front();
      if (ch != lvl.chan)
        report_mismatch($sformatf("word %0d channel got %0d want %0d",
                                  levels_checked, ch, lvl.chan));
      if (rms != lvl.rms)
        report_mismatch($sformatf("word %0d ch %0d rms got %0d want %0d",
                                  levels_checked, lvl.chan, rms, lvl.rms));
      if (peak != lvl.peak)
        report_mismatch($sformatf("word %0d ch %0d peak got %0d want %0d",
                                  levels_checked, lvl.chan, peak, lvl.peak));
    endtask

    // Flag any level word that never showed up
    task check_drained();
      if (expected_levels.size() != 0)
        report_mismatch($sformatf("%0d level words never delivered",
                                  expected_levels.size()));
    endtask
  endclass

endpackage

>>> dv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import level_meter_sb_pkg::*;

  localparam logic [ablm_pkg::SMP_W-1:0] FULL_NEG = 24'h800000;
  localparam logic [ablm_pkg::SMP_W-1:0] FULL_POS = 24'h7FFFFF;
  // Leave margin after the last result before touching the register
  localparam int SETTLE_CYCLES = 120;
  localparam int PHASE_ITEMS   = 45;
  localparam int NUM_PHASES    = 12;
  // Roughly 1650 words in the run; the limit leaves wide margin over that
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  logic                                clk;
  logic                                rst_n       = 1'b0;
  logic                                cfg_wr_en   = 1'b0;
  logic        [ablm_pkg::CFG_W-1:0]   cfg_wr_data = '0;
  logic                                in_valid    = 1'b0;
  logic                                in_stall;
  logic        [ablm_pkg::CH_W-1:0]    in_channel  = '0;
  logic signed [ablm_pkg::SMP_W-1:0]   in_sample   = '0;
  logic                                out_valid;
  logic                                out_stall   = 1'b0;
  logic        [ablm_pkg::CH_W-1:0]    out_channel;
  logic        [ablm_pkg::SMP_W-1:0]   out_rms_level;
  logic        [ablm_pkg::SMP_W-1:0]   out_peak_level;

  level_scoreboard sb;
  int          send_idle_pct = 23;
  int          recv_idle_pct = 84;
  int          samples_sent  = 0;
  int          length_writes = 0;
  int unsigned cycle_count   = 0;

  audio_block_level_meter #(
    .CHANNELS  (NUM_CH),
    .MAX_BLOCK (MAX_BLOCK)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_channel     (in_channel),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_channel    (out_channel),
    .out_rms_level  (out_rms_level),
    .out_peak_level (out_peak_level)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Check delivered level words, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_level(out_channel, out_rms_level, out_peak_level);
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Idle at random, then hold one sample word until it is taken
  task automatic send_sample(input logic [ablm_pkg::CH_W-1:0] ch,
                             input logic [ablm_pkg::SMP_W-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_channel <= ch;
    in_sample  <= smp;
    do @(posedge clk); while (in_stall);
    sb.note_sample(ch, smp);
    samples_sent++;
  endtask

  // Drop valid and hold until every pending level word has arrived
  task automatic hold_for_levels();
    in_valid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
  endtask

  task automatic settle();
    hold_for_levels();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_block_length(input logic [ablm_pkg::CFG_W-1:0] len);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    sb.set_block_length(len);
    cfg_wr_en <= 1'b0;
    length_writes++;
  endtask

  function automatic logic [ablm_pkg::SMP_W-1:0] random_sample();
    logic [ablm_pkg::SMP_W-1:0] small_val;
    small_val = ablm_pkg::SMP_W'($urandom_range(511)) - 24'd256;
    case ($urandom_range(9))
      0:       return FULL_NEG;
      1:       return FULL_POS;
      2:       return '0;
      3:       return small_val;
      default: return ablm_pkg::SMP_W'($urandom);
    endcase
  endfunction

  function automatic logic [ablm_pkg::CFG_W-1:0] random_block_length();
    case ($urandom_range(19))
      0:       return '0;
      1:       return 13'd1;
      2:       return 13'd4096;
      3:       return 13'd8191;
      4:       return ablm_pkg::CFG_W'($urandom_range(8190, 4097));
      5, 6, 7, 8, 9:
               return ablm_pkg::CFG_W'($urandom_range(4, 2));
      10, 11, 12, 13, 14, 15:
               return ablm_pkg::CFG_W'($urandom_range(12, 5));
      default: return ablm_pkg::CFG_W'($urandom_range(40, 13));
    endcase
  endfunction

  initial begin
    int span;
    int offset;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default block length: one full block on channel 1
    for (int i = 0; i < 1024; i++)
      send_sample(3'd1, random_sample());

    // Single-sample blocks at the field extremes
    write_block_length(13'd1);
    send_sample(3'd0, FULL_NEG);
    send_sample(3'd7, FULL_POS);
    send_sample(3'd3, '0);
    send_sample(3'd4, 24'hFFFFFF);
    send_sample(3'd5, 24'h000001);
    send_sample(3'd6, 24'h555555);
    send_sample(3'd2, 24'hAAAAAA);

    // Zero length acts as one
    write_block_length('0);
    send_sample(3'd1, FULL_NEG);
    send_sample(3'd7, 24'd12345);

    // Short blocks, full-scale negative gives the top RMS code
    write_block_length(13'd3);
    send_sample(3'd2, FULL_NEG);
    send_sample(3'd2, FULL_POS);
    send_sample(3'd2, '0);
    for (int i = 0; i < 3; i++)
      send_sample(3'd0, FULL_NEG);

    // Lower the length while two channels are part way through a block
    write_block_length(13'd8);
    for (int i = 0; i < 5; i++)
      send_sample(3'd4, random_sample());
    for (int i = 0; i < 3; i++)
      send_sample(3'd5, random_sample());
    write_block_length(13'd2);
    send_sample(3'd4, random_sample());
    send_sample(3'd5, random_sample());

    // Oversized length saturates: a long full-scale run stays open,
    // then a lower length closes it on the next sample
    write_block_length(13'd8191);
    for (int i = 0; i < 48; i++)
      send_sample(3'd5, (i % 2 == 1) ? FULL_POS : FULL_NEG);
    write_block_length(13'd16);
    send_sample(3'd5, FULL_NEG);

    // Random phases, each with its own length and channel spread
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == 4) begin
        send_idle_pct = 84;
        recv_idle_pct = 23;
      end else if (phase == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_block_length(phase == 0 ? 13'd4096 : random_block_length());
      case ($urandom_range(3))
        0:       span = 7;
        1:       span = 3;
        2:       span = 1;
        default: span = 0;
      endcase
      offset = $urandom_range(7);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2)
          hold_for_levels();
        send_sample(ablm_pkg::CH_W'(offset + $urandom_range(span)), random_sample());
      end
    end

    settle();
    sb.check_drained();
    $display("Run covered %0d samples and %0d level words over %0d block length settings,",
             samples_sent, sb.levels_checked, length_writes);
    $display("including zero, saturated and mid-block lowered lengths under varied stalls.");
    if (sb.mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
